/* src/iee_pkg.sv */
// Package for the infix expression evaluator: payload structs, operator codes,
// character constants and the command and status structs between controller and datapath.
// No dependencies.
package iee_pkg;

    localparam int IEE_DATA_WIDTH = 32;
    localparam int IEE_MAX_WIDTH  = 64;
    localparam int IEE_VALUE_W    = 32;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [3:0] DEC_TEN   = 4'd10;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic signed [IEE_VALUE_W-1:0] value;
        logic                          divide_error;
    } t_out_beat;

    typedef struct packed {
        logic cap;
        logic decode;
        logic apply;
        logic iter;
        logic set_op;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic last;
        logic saw_digit;
        logic long_op;
        logic iter_done;
        logic out_free;
    } t_dp_status;

endpackage

/* src/infix_expression_evaluator_unit.sv */
// Top level of the infix expression evaluator: controller plus datapath.
// Depends on iee_pkg, iee_ctrl and iee_datapath.
//
//  Channel | Valid       | Stall        | Payload (iee_pkg)
//  --------+-------------+--------------+-------------------------------------
//  input   | i_in_valid  | o_in_stall   | i_in_data  : t_in_beat  (character, last)
//  output  | o_out_valid | i_out_stall  | o_out_data : t_out_beat (value, divide_error)
//
// A beat passes through capture and decode; one that applies +, - or a division by zero
// also passes through apply, and one that applies * or a division by a non-zero number
// then runs the serial multiply/divide unit, retiring one bit per cycle.
// A last beat then loads the output register. A result waits there under stall
// while the next beats are taken; the next last beat holds the input stalled until it frees.
// Reset is synchronous and active low; it clears the expression state and the output valid.
module infix_expression_evaluator_unit #(
    parameter int DATA_WIDTH = iee_pkg::IEE_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  iee_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output iee_pkg::t_out_beat o_out_data
);

    iee_pkg::t_dp_cmd    cmd;
    iee_pkg::t_dp_status status;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    iee_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* src/iee_datapath.sv */
// Datapath of the infix expression evaluator: expression state, shared serial
// multiply/divide unit and the output register. Depends on iee_pkg.
module iee_datapath #(
    parameter int DATA_WIDTH = iee_pkg::IEE_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iee_pkg::t_in_beat  i_in_data,
    input  iee_pkg::t_dp_cmd   i_cmd,
    output iee_pkg::t_dp_status o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output iee_pkg::t_out_beat o_out_data
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [7:0]   r_char;
    logic         r_last;
    logic [W-1:0] r_num, n_num;
    logic [W-1:0] r_sum, n_sum;
    logic [W-1:0] r_term, n_term;
    iee_pkg::t_op r_op, n_op;
    logic         r_saw, n_saw;
    logic         r_err, n_err;

    // Serial unit: r_acc holds the product or the partial remainder, r_opa the
    // multiplicand or the dividend shifting into the quotient, r_opb the
    // multiplier or the divisor.
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_opa, n_opa;
    logic [W-1:0]  r_opb, n_opb;
    logic          r_div, n_div;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;

    logic              r_out_valid, n_out_valid;
    iee_pkg::t_out_beat r_out, n_out;

    logic         is_digit, is_op;
    iee_pkg::t_op char_op;
    logic [W-1:0] digit_val;
    logic [W:0]   trial;
    logic [W-1:0] term_mag, num_mag;
    logic [W-1:0] total;
    logic [iee_pkg::IEE_MAX_WIDTH-1:0] total_ext;
    logic         out_take, out_free;

    always_comb begin
        is_digit = (r_char inside {[iee_pkg::CH_ZERO:iee_pkg::CH_NINE]});
        is_op    = 1'b1;
        case (r_char)
            iee_pkg::CH_PLUS:   char_op = iee_pkg::OP_PLUS;
            iee_pkg::CH_MINUS:  char_op = iee_pkg::OP_MINUS;
            iee_pkg::CH_TIMES:  char_op = iee_pkg::OP_TIMES;
            iee_pkg::CH_DIVIDE: char_op = iee_pkg::OP_DIVIDE;
            default: begin
                char_op = iee_pkg::OP_PLUS;
                is_op   = 1'b0;
            end
        endcase
    end

    assign digit_val = W'(r_char[3:0]);
    assign term_mag  = r_term[W-1] ? (~r_term + W'(1)) : r_term;
    assign num_mag   = r_num[W-1] ? (~r_num + W'(1)) : r_num;
    assign trial     = {r_acc, r_opa[W-1]} - {1'b0, r_opb};
    assign total     = r_sum + r_term;

    always_comb begin
        total_ext        = '0;
        total_ext[W-1:0] = total;
    end

    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_num       = r_num;
        n_sum       = r_sum;
        n_term      = r_term;
        n_op        = r_op;
        n_saw       = r_saw;
        n_err       = r_err;
        n_acc       = r_acc;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_div       = r_div;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_take;

        if (i_cmd.decode && is_digit) begin
            // Times ten as two shifts and an add.
            n_num = (r_num << 3) + (r_num << 1) + digit_val;
            n_saw = 1'b1;
        end

        if (i_cmd.apply) begin
            n_num = '0;
            n_saw = 1'b0;
            n_acc = '0;
            n_cnt = CW'(W - 1);
            case (r_op)
                iee_pkg::OP_PLUS: begin
                    n_sum  = r_sum + r_term;
                    n_term = r_num;
                end
                iee_pkg::OP_MINUS: begin
                    n_sum  = r_sum + r_term;
                    n_term = ~r_num + W'(1);
                end
                iee_pkg::OP_TIMES: begin
                    n_div = 1'b0;
                    n_opa = r_term;
                    n_opb = r_num;
                end
                default: begin
                    if (r_num == '0) begin
                        n_err  = 1'b1;
                        n_term = '0;
                    end else begin
                        n_div = 1'b1;
                        n_neg = r_term[W-1] ^ r_num[W-1];
                        n_opa = term_mag;
                        n_opb = num_mag;
                    end
                end
            endcase
        end

        if (i_cmd.iter) begin
            n_cnt = r_cnt - CW'(1);
            if (r_div) begin
                if (!trial[W]) begin
                    n_acc = trial[W-1:0];
                    n_opa = {r_opa[W-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[W-2:0], r_opa[W-1]};
                    n_opa = {r_opa[W-2:0], 1'b0};
                end
            end else begin
                if (r_opb[0]) begin
                    n_acc = r_acc + r_opa;
                end
                n_opa = r_opa << 1;
                n_opb = r_opb >> 1;
            end
            if (r_cnt == '0) begin
                if (r_div) begin
                    n_term = r_neg ? (~n_opa + W'(1)) : n_opa;
                end else begin
                    n_term = n_acc;
                end
            end
        end

        if (i_cmd.set_op && is_op) begin
            n_op = char_op;
        end

        if (i_cmd.emit) begin
            n_out.value        = total_ext[iee_pkg::IEE_VALUE_W-1:0];
            n_out.divide_error = r_err;
            n_out_valid        = 1'b1;
            n_num              = '0;
            n_sum              = '0;
            n_term             = '0;
            n_op               = iee_pkg::OP_PLUS;
            n_saw              = 1'b0;
            n_err              = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= '0;
            r_sum       <= '0;
            r_term      <= '0;
            r_op        <= iee_pkg::OP_PLUS;
            r_saw       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_num       <= n_num;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_op        <= n_op;
            r_saw       <= n_saw;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_char <= i_in_data.character;
            r_last <= i_in_data.last;
        end
        r_acc <= n_acc;
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_div <= n_div;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    always_comb begin
        o_status.is_digit  = is_digit;
        o_status.is_op     = is_op;
        o_status.last      = r_last;
        o_status.saw_digit = r_saw;
        o_status.long_op   = (r_op == iee_pkg::OP_TIMES) ||
                             ((r_op == iee_pkg::OP_DIVIDE) && (r_num != '0));
        o_status.iter_done = (r_cnt == '0);
        o_status.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/iee_ctrl.sv */
// Controller of the infix expression evaluator: sequences capture, decode,
// operator application, serial steps and result emission. Depends on iee_pkg.
module iee_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iee_pkg::t_dp_status i_status,
    output iee_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_APPLY  = 5'b00100,
        S_ITER   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   need_apply;

    // One application at most per beat: an operator after a number, or the
    // closing flush of the last beat when a number is outstanding.
    assign need_apply = (i_status.is_op && i_status.saw_digit) ||
                        (i_status.last && (i_status.saw_digit || i_status.is_digit));

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (need_apply) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.set_op = 1'b1;
                    n_state      = i_status.last ? S_EMIT : S_IDLE;
                end
            end
            S_APPLY: begin
                o_cmd.apply  = 1'b1;
                o_cmd.set_op = 1'b1;
                if (i_status.long_op) begin
                    n_state = S_ITER;
                end else begin
                    n_state = i_status.last ? S_EMIT : S_IDLE;
                end
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_status.iter_done) begin
                    n_state = i_status.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* test/iee_result_checker.sv */
// Result checker for the infix expression evaluator: it watches both channels, predicts
// each result from the accepted characters and compares it with what the block hands out.
// Depends on iee_pkg.
module iee_result_checker
    import iee_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_mismatches,
    output int        o_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = IEE_DATA_WIDTH;

    logic [W-1:0] number_acc;
    logic [W-1:0] sum_of_terms;
    logic [W-1:0] open_term;
    t_op          op_held;
    logic         digit_seen;
    logic         zero_divide_seen;

    t_out_beat    awaited_results[$];
    int           mismatches = 0;
    int           awaited_count = 0;

    assign o_mismatches = mismatches;
    assign o_awaited    = awaited_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_expression();
        number_acc       = '0;
        sum_of_terms     = '0;
        open_term        = '0;
        op_held          = OP_PLUS;
        digit_seen       = 1'b0;
        zero_divide_seen = 1'b0;
    endtask

    // Signed division truncating toward zero, worked on magnitudes so that the most
    // negative value divided by minus one wraps back to itself.
    function automatic logic [W-1:0] truncated_quotient(input logic [W-1:0] num,
                                                        input logic [W-1:0] den);
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W-1:0] quot;
        num_mag = num[W-1] ? -num : num;
        den_mag = den[W-1] ? -den : den;
        quot    = num_mag / den_mag;
        return (num[W-1] ^ den[W-1]) ? -quot : quot;
    endfunction

    task automatic fold_pending_operator();
        case (op_held)
            OP_PLUS: begin
                sum_of_terms = sum_of_terms + open_term;
                open_term    = number_acc;
            end
            OP_MINUS: begin
                sum_of_terms = sum_of_terms + open_term;
                open_term    = -number_acc;
            end
            OP_TIMES: begin
                open_term = open_term * number_acc;
            end
            default: begin
                if (number_acc == '0) begin
                    zero_divide_seen = 1'b1;
                    open_term        = '0;
                end else begin
                    open_term = truncated_quotient(open_term, number_acc);
                end
            end
        endcase
        number_acc = '0;
        digit_seen = 1'b0;
    endtask

    task automatic evaluate_character(input t_in_beat beat, output logic produced,
                                      output t_out_beat outcome);
        logic is_op;
        t_op  op_code;
        produced = 1'b0;
        outcome  = '0;
        is_op    = 1'b1;
        op_code  = OP_PLUS;
        if (beat.character >= CH_ZERO && beat.character <= CH_NINE) begin
            number_acc = number_acc * DEC_TEN + (beat.character - CH_ZERO);
            digit_seen = 1'b1;
            is_op      = 1'b0;
        end else begin
            case (beat.character)
                CH_PLUS:   op_code = OP_PLUS;
                CH_MINUS:  op_code = OP_MINUS;
                CH_TIMES:  op_code = OP_TIMES;
                CH_DIVIDE: op_code = OP_DIVIDE;
                default:   is_op   = 1'b0;
            endcase
        end
        // An operator with no number since the previous one only replaces it.
        if (is_op) begin
            if (digit_seen) begin
                fold_pending_operator();
            end
            op_held = op_code;
        end
        if (beat.last) begin
            if (digit_seen) begin
                fold_pending_operator();
            end
            outcome.value        = sum_of_terms + open_term;
            outcome.divide_error = zero_divide_seen;
            produced             = 1'b1;
            clear_expression();
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic      produced;
        t_out_beat outcome;
        t_out_beat wanted;
        if (!i_rst_n) begin
            clear_expression();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                evaluate_character(i_in_data, produced, outcome);
                if (produced) begin
                    awaited_results.push_back(outcome);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d divide_error %0b",
                                              i_out_data.value, i_out_data.divide_error));
                end else begin
                    wanted = awaited_results.pop_front();
                    if (i_out_data.value !== wanted.value) begin
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  i_out_data.value, wanted.value));
                    end
                    if (i_out_data.divide_error !== wanted.divide_error) begin
                        report_mismatch($sformatf("divide_error %0b, expected %0b",
                                                  i_out_data.divide_error,
                                                  wanted.divide_error));
                    end
                end
            end
            awaited_count = awaited_results.size();
        end
    end

endmodule

/* test/tb_infix_expression_evaluator_unit.sv */
// Testbench top for the infix expression evaluator: clock, reset, character stimulus,
// result-side stall pattern and the verdict. Depends on iee_pkg,
// infix_expression_evaluator_unit and iee_result_checker.
module tb_infix_expression_evaluator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import iee_pkg::*;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam int         ITEM_TARGET  = 1650;
    // Longest beat is a serial multiply or divide plus the output load; this is ample.
    localparam int         DRAIN_CYCLES = 64;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    int         mismatch_count;
    int         results_awaited;
    logic [7:0] expr_chars[$];
    int         items_sent = 0;
    int         burst_left = 0;
    logic       feeding    = 1'b0;

    infix_expression_evaluator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    iee_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_mismatches (mismatch_count),
        .o_awaited    (results_awaited)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // The result side stalls in phases of varying density, some of them free of stalls.
    initial begin : stall_pattern
        int mode;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    task automatic lower_valid();
        if (feeding) begin
            i_in_valid <= 1'b0;
            feeding = 1'b0;
        end
    endtask

    task automatic send_beat(input logic [7:0] ch, input logic is_last);
        t_in_beat beat;
        int       gap;
        if (burst_left == 0) begin
            // A quarter of the bursts follow on from the previous one without a gap.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                lower_valid();
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        beat.character = ch;
        beat.last      = is_last;
        i_in_data  <= beat;
        i_in_valid <= 1'b1;
        feeding = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_expression();
        foreach (expr_chars[k]) begin
            send_beat(expr_chars[k], k == expr_chars.size() - 1);
        end
        items_sent += expr_chars.size();
    endtask

    task automatic add_text(input string text);
        foreach (text[k]) begin
            expr_chars.push_back(text[k]);
        end
    endtask

    task automatic run_text(input string text);
        expr_chars.delete();
        add_text(text);
        send_expression();
    endtask

    task automatic add_number(input logic [31:0] value);
        string digits;
        digits = $sformatf("%0d", value);
        foreach (digits[k]) begin
            // A space inside a number does not split it.
            if (k > 0 && $urandom_range(0, 9) == 0) begin
                expr_chars.push_back(CH_SPACE);
            end
            expr_chars.push_back(digits[k]);
        end
    endtask

    task automatic push_operator();
        if ($urandom_range(0, 5) == 0) begin
            expr_chars.push_back(CH_SPACE);
        end
        case ($urandom_range(0, 3))
            0: expr_chars.push_back(CH_PLUS);
            1: expr_chars.push_back(CH_MINUS);
            2: expr_chars.push_back(CH_TIMES);
            default: expr_chars.push_back(CH_DIVIDE);
        endcase
        if ($urandom_range(0, 5) == 0) begin
            expr_chars.push_back(CH_SPACE);
        end
    endtask

    task automatic push_any_token();
        case ($urandom_range(0, 3))
            0: expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            1: push_operator();
            2: expr_chars.push_back(CH_SPACE);
            default: expr_chars.push_back(8'($urandom_range(8'h61, 8'h7A)));
        endcase
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            7, 8: return $urandom_range(100, 99999);
            9: return $urandom;
            default: return $urandom_range(1, 99);
        endcase
    endfunction

    task automatic build_expression();
        int kind;
        int terms;
        expr_chars.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // The most negative term divided by a divisor that wraps to minus one.
            add_text("-2147483648/4294967295");
        end else if (kind == 1) begin
            // A number long enough to wrap the accumulator, then one more term.
            add_text($sformatf("%0d%0d", $urandom, $urandom));
            push_operator();
            add_number(pick_operand());
        end else if (kind <= 14) begin
            if ($urandom_range(0, 4) == 0) begin
                expr_chars.push_back(CH_MINUS);
            end
            terms = $urandom_range(1, 6);
            for (int t = 0; t < terms; t++) begin
                if (t > 0) begin
                    push_operator();
                end
                add_number(pick_operand());
            end
        end else if (kind <= 17) begin
            repeat ($urandom_range(1, 10)) push_any_token();
        end else begin
            repeat ($urandom_range(1, 5)) expr_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic hold_until_drained();
        lower_valid();
        do @(posedge i_clk); while (results_awaited != 0);
    endtask

    initial begin : stimulus
        logic paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Division by zero; a leading minus with a space inside a number; an operator
        // replacing one that had no number; an ignored letter; a trailing operator
        // dropped with the extreme character codes at the end.
        run_text("7/0");
        run_text("-3*4 1");
        run_text("5+*2");
        run_text("1a2/5");
        expr_chars.delete();
        add_text("9-");
        expr_chars.push_back(8'hFF);
        expr_chars.push_back(8'h00);
        send_expression();
        hold_until_drained();

        while (items_sent < ITEM_TARGET) begin
            build_expression();
            send_expression();
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_awaited == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* infix_expression_evaluator_unit.f */
src/iee_pkg.sv
src/iee_datapath.sv
src/iee_ctrl.sv
src/infix_expression_evaluator_unit.sv
test/iee_result_checker.sv
test/tb_infix_expression_evaluator_unit.sv
